[src/bounded_integer_stack_macros.svh]
// Assertion macros shared by the bounded integer stack RTL.
// Included by bis_ctrl; depends on nothing else.
`ifndef BOUNDED_INTEGER_STACK_MACROS_SVH
`define BOUNDED_INTEGER_STACK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_integer_stack: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_integer_stack: next-cycle check failed");

`endif

[src/bis_pkg.sv]
// Shared types and codes of the bounded integer stack.
// Used by bis_ctrl, bis_datapath and the bounded_integer_stack top level.
package bis_pkg;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [3:0]         index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic [3:0]         position;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic take_result;
    logic scan_issue;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_needed;
    logic cnt_zero;
    logic scan_last;
  } dp_sts_t;

endpackage

[src/bounded_integer_stack.sv]
// Top level of the bounded integer stack: controller plus datapath.
// Depends on bis_pkg, bis_ctrl and bis_datapath.
//
// Usage: drive in_req and raise start; the request is taken at a rising edge
// where start is high and busy is low. Each request is one operation: push,
// pop, peek, search, read at an index or clear. Exactly one response follows,
// shown on out_rsp for a single cycle while out_valid is high; the receiver
// cannot hold it off and must take it in that cycle.
// Every response carries the entry count, an empty flag and the minimum and
// maximum of the stored words, which the block rescans after each operation.
// After the accepting edge the controller executes the operation, then fetches
// the word read or prepares, then scans the stored words and drains the last
// read before out_valid rises; an empty stack skips the scan. busy drops the
// cycle after out_valid, so no new request is taken before then. The scan pace
// is set by the single read port of the entry memory, walked one word per cycle.
// Reset (rst_n low at a clock edge) empties the stack and returns the
// controller to idle; stored words are not cleared and are never read
// before being pushed again.
module bounded_integer_stack #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bis_pkg::req_t  in_req,
  output logic           out_valid,
  output bis_pkg::rsp_t  out_rsp
);

  bis_pkg::ctl_cmd_t cmd;
  bis_pkg::dp_sts_t  sts;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  bis_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

[src/bis_ctrl.sv]
// Controller state machine of the bounded integer stack.
// Depends on bis_pkg and bounded_integer_stack_macros.svh.
`include "bounded_integer_stack_macros.svh"

module bis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output bis_pkg::ctl_cmd_t  cmd,
  input  bis_pkg::dp_sts_t   sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.rd_needed ? S_FETCH : S_PREP;
      end
      S_FETCH: begin
        // The word read during execution is in the read register now.
        cmd.take_result = 1'b1;
        state_nxt       = sts.cnt_zero ? S_DONE : S_SCAN;
      end
      S_PREP: begin
        state_nxt = sts.cnt_zero ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  `BIS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && state_r == S_EXEC)
  `BIS_ASSERT_SAME(a_scan_nonempty, clk, rst_n, state_r == S_SCAN, !sts.cnt_zero)
  `BIS_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, out_valid, !out_valid && !busy)

endmodule

[src/bis_datapath.sv]
// Datapath of the bounded integer stack: entry memory, count, scan unit.
// Depends on bis_pkg; driven by bis_ctrl through command and status structs.
module bis_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bis_pkg::req_t     in_req,
  input  bis_pkg::ctl_cmd_t cmd,
  output bis_pkg::dp_sts_t  sts,
  output bis_pkg::rsp_t     out_rsp
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [2:0]                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0]        val_r, val_nxt;
  logic [3:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic signed [DATA_WIDTH-1:0] result_r, result_nxt;
  logic [2:0]                   status_r, status_nxt;
  logic [3:0]                   pos_r, pos_nxt;
  logic                         found_r, found_nxt;
  logic                         have_r, have_nxt;
  logic signed [DATA_WIDTH-1:0] lo_r, lo_nxt;
  logic signed [DATA_WIDTH-1:0] hi_r, hi_nxt;
  logic [AW-1:0]                scan_r, scan_nxt;
  logic                         pend_r;
  logic [AW-1:0]                pend_idx_r;
  logic [DATA_WIDTH-1:0]        rdata_r;

  logic                         wr_en;
  logic [AW-1:0]                rd_addr;
  logic                         idx_ok;
  logic signed [DATA_WIDTH-1:0] rword;

  assign rword  = $signed(rdata_r);
  assign idx_ok = CMPW'(idx_r) < CMPW'(cnt_r);

  assign sts.rd_needed = (((op_r == bis_pkg::OP_POP) || (op_r == bis_pkg::OP_PEEK))
                          && (cnt_r != '0))
                         || ((op_r == bis_pkg::OP_READ) && idx_ok);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.scan_last = (scan_r == AW'(cnt_r - 1'b1));

  always_comb begin
    op_nxt     = op_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    result_nxt = result_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    have_nxt   = have_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    scan_nxt   = scan_r;
    wr_en      = 1'b0;
    rd_addr    = scan_r;

    if (cmd.load) begin
      op_nxt  = in_req.operation;
      val_nxt = DATA_WIDTH'(in_req.value);
      idx_nxt = in_req.index;
    end

    if (cmd.exec) begin
      result_nxt = '0;
      status_nxt = bis_pkg::ST_OK;
      pos_nxt    = '0;
      found_nxt  = 1'b0;
      have_nxt   = 1'b0;
      scan_nxt   = '0;
      case (op_r)
        bis_pkg::OP_PUSH: begin
          if (cnt_r < CW'(DEPTH)) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            status_nxt = bis_pkg::ST_FULL;
          end
        end
        bis_pkg::OP_POP, bis_pkg::OP_PEEK: begin
          if (cnt_r == '0) begin
            status_nxt = bis_pkg::ST_EMPTY;
          end else begin
            rd_addr = AW'(cnt_r - 1'b1);
            if (op_r == bis_pkg::OP_POP) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        bis_pkg::OP_SEARCH: begin
          status_nxt = bis_pkg::ST_NOT_FOUND;
        end
        bis_pkg::OP_READ: begin
          if (idx_ok) begin
            rd_addr = AW'(idx_r);
          end else begin
            status_nxt = bis_pkg::ST_RANGE;
          end
        end
        bis_pkg::OP_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.take_result) begin
      result_nxt = rword;
    end

    if (cmd.scan_issue) begin
      scan_nxt = scan_r + 1'b1;
    end

    // Each word read by the scan arrives in the read register the cycle after its address.
    if (pend_r) begin
      if ((op_r == bis_pkg::OP_SEARCH) && !found_r && (rdata_r == val_r)) begin
        found_nxt  = 1'b1;
        pos_nxt    = 4'(pend_idx_r);
        status_nxt = bis_pkg::ST_OK;
      end
      if (!have_r) begin
        have_nxt = 1'b1;
        lo_nxt   = rword;
        hi_nxt   = rword;
      end else begin
        if (rword < lo_r) begin
          lo_nxt = rword;
        end
        if (rword > hi_r) begin
          hi_nxt = rword;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= val_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    result_r   <= result_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    scan_r     <= scan_nxt;
    pend_idx_r <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      pend_r  <= cmd.scan_issue;
      found_r <= found_nxt;
      have_r  <= have_nxt;
    end
  end

  assign out_rsp.result_value = 32'(result_r);
  assign out_rsp.status       = status_r;
  assign out_rsp.position     = pos_r;
  assign out_rsp.entry_count  = 5'(cnt_r);
  assign out_rsp.is_empty     = (cnt_r == '0);
  assign out_rsp.min_value    = have_r ? 32'(lo_r) : 32'sd0;
  assign out_rsp.max_value    = have_r ? 32'(hi_r) : 32'sd0;

endmodule

[test/bounded_integer_stack_test.sv]
// Self-checking testbench for the bounded integer stack: a directed script of
// requests, then constrained-by-hand random traffic checked against a shadow stack.
// Depends on bis_pkg and the bounded_integer_stack top level.
module bounded_integer_stack_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 16;
  localparam int RANDOM_ITEMS = 525;
  localparam int MAX_PAUSE = 30;
  localparam int MAX_PRINTED = 40;
  // Operation codes the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    bis_pkg::req_t req;
    int            reps;
    bit            fixed;
    bis_pkg::rsp_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  bis_pkg::req_t in_req = '0;
  logic busy;
  logic out_valid;
  bis_pkg::rsp_t out_rsp;

  logic signed [31:0] shadow_words [STACK_DEPTH];
  int                 shadow_count = 0;
  bis_pkg::rsp_t      awaited_rsp [$];
  script_row_t        script [$];
  int                 idle_pct = 0;
  int                 errors = 0;

  bounded_integer_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    errors++;
  endtask

  // Applies one request to the shadow stack and returns the response it should get.
  function automatic bis_pkg::rsp_t predict_stack_op(input bis_pkg::req_t r);
    bis_pkg::rsp_t o;
    int            i;
    o = '0;
    case (r.operation)
      bis_pkg::OP_PUSH: begin
        if (shadow_count < STACK_DEPTH) begin
          shadow_words[shadow_count] = r.value;
          shadow_count++;
        end else begin
          o.status = bis_pkg::ST_FULL;
        end
      end
      bis_pkg::OP_POP, bis_pkg::OP_PEEK: begin
        if (shadow_count == 0) begin
          o.status = bis_pkg::ST_EMPTY;
        end else begin
          o.result_value = shadow_words[shadow_count - 1];
          if (r.operation == bis_pkg::OP_POP) shadow_count--;
        end
      end
      bis_pkg::OP_SEARCH: begin
        // Walk downward so that the lowest matching position wins.
        o.status = bis_pkg::ST_NOT_FOUND;
        for (i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_words[i] == r.value) begin
            o.position = i[3:0];
            o.status = bis_pkg::ST_OK;
          end
        end
      end
      bis_pkg::OP_READ: begin
        if (int'(r.index) < shadow_count) o.result_value = shadow_words[r.index];
        else o.status = bis_pkg::ST_RANGE;
      end
      bis_pkg::OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    o.entry_count = shadow_count[4:0];
    o.is_empty = (shadow_count == 0);
    if (shadow_count > 0) begin
      o.min_value = shadow_words[0];
      o.max_value = shadow_words[0];
      for (i = 1; i < shadow_count; i++) begin
        if (shadow_words[i] < o.min_value) o.min_value = shadow_words[i];
        if (shadow_words[i] > o.max_value) o.max_value = shadow_words[i];
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      // Small values make duplicates likely, which exercises the search order.
      4, 5: return 32'($urandom_range(0, 7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic bis_pkg::req_t random_request();
    bis_pkg::req_t r;
    int            pick;
    r.value = random_word();
    r.index = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      r.operation = bis_pkg::OP_PUSH;
    end else if (pick < 58) begin
      r.operation = bis_pkg::OP_POP;
    end else if (pick < 66) begin
      r.operation = bis_pkg::OP_PEEK;
    end else if (pick < 80) begin
      r.operation = bis_pkg::OP_SEARCH;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        r.value = shadow_words[$urandom_range(0, shadow_count - 1)];
    end else if (pick < 94) begin
      r.operation = bis_pkg::OP_READ;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        r.index = 4'($urandom_range(0, shadow_count - 1));
    end else if (pick < 97) begin
      r.operation = bis_pkg::OP_CLEAR;
    end else begin
      r.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [31:0] v,
                                  input logic [3:0] ix, input int reps,
                                  input bit fixed, input bis_pkg::rsp_t want);
    script_row_t row;
    row.req.operation = op;
    row.req.value = v;
    row.req.index = ix;
    row.reps = reps;
    row.fixed = fixed;
    row.want = want;
    script.push_back(row);
  endfunction

  // With a chance of idle_pct percent, drops start for a random stretch, with junk on the request bus.
  task automatic sender_pause();
    logic [63:0] junk;
    if ($urandom_range(1, 100) <= idle_pct) begin
      junk = {$urandom, $urandom};
      start <= 1'b0;
      in_req <= junk[$bits(bis_pkg::req_t)-1:0];
      repeat ($urandom_range(1, MAX_PAUSE)) @(posedge clk);
    end
  endtask

  // Holds the request until the block takes it, then records what it should return.
  task automatic issue(input bis_pkg::req_t r, input bit fixed, input bis_pkg::rsp_t want);
    bis_pkg::rsp_t predicted;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    predicted = predict_stack_op(r);
    awaited_rsp.push_back(fixed ? want : predicted);
  endtask

  always @(posedge clk) begin
    bis_pkg::rsp_t want;
    if (rst_n && out_valid) begin
      if (awaited_rsp.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp.result_value !== want.result_value)
          report($sformatf("result_value %h, want %h", out_rsp.result_value, want.result_value));
        if (out_rsp.status !== want.status)
          report($sformatf("status %0d, want %0d", out_rsp.status, want.status));
        if (out_rsp.position !== want.position)
          report($sformatf("position %0d, want %0d", out_rsp.position, want.position));
        if (out_rsp.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, want %0d", out_rsp.entry_count, want.entry_count));
        if (out_rsp.is_empty !== want.is_empty)
          report($sformatf("is_empty %b, want %b", out_rsp.is_empty, want.is_empty));
        if (out_rsp.min_value !== want.min_value)
          report($sformatf("min_value %h, want %h", out_rsp.min_value, want.min_value));
        if (out_rsp.max_value !== want.max_value)
          report($sformatf("max_value %h, want %h", out_rsp.max_value, want.max_value));
      end
    end
  end

  initial begin
    int k;
    int n;
    int phase;
    // Empty stack: every read-type request fails.
    add_row(bis_pkg::OP_POP, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_EMPTY, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    add_row(bis_pkg::OP_PEEK, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_EMPTY, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    add_row(bis_pkg::OP_SEARCH, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_NOT_FOUND, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    add_row(bis_pkg::OP_READ, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_RANGE, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    add_row(bis_pkg::OP_READ, 32'h0, 4'd15, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_RANGE, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    // Extremes of the word.
    add_row(bis_pkg::OP_PUSH, 32'h7fff_ffff, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_OK, 4'd0, 5'd1, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff});
    add_row(bis_pkg::OP_PUSH, 32'h8000_0000, 4'd15, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_OK, 4'd0, 5'd2, 1'b0, 32'h8000_0000, 32'h7fff_ffff});
    add_row(bis_pkg::OP_PUSH, 32'hffff_ffff, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_PUSH, 32'h0, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_SEARCH, 32'h0, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_SEARCH, 32'h8000_0000, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_SEARCH, 32'd12345, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_READ, 32'h0, 4'd1, 1, 1'b0, '0);
    add_row(bis_pkg::OP_READ, 32'h0, 4'd4, 1, 1'b0, '0);
    add_row(bis_pkg::OP_PEEK, 32'h0, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_POP, 32'h0, 4'd0, 1, 1'b0, '0);
    add_row(OP_SPARE_LO, 32'h1234_5678, 4'd3, 1, 1'b0, '0);
    add_row(OP_SPARE_HI, 32'hfedc_ba98, 4'd9, 1, 1'b0, '0);
    // Three entries remain; thirteen pushes fill the stack, the next is dropped.
    add_row(bis_pkg::OP_PUSH, 32'h5a5a_5a5a, 4'd0, 13, 1'b0, '0);
    add_row(bis_pkg::OP_PUSH, 32'h1, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_READ, 32'h0, 4'd15, 1, 1'b0, '0);
    add_row(bis_pkg::OP_SEARCH, 32'h5a5a_5a5a, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_POP, 32'h0, 4'd0, 1, 1'b0, '0);
    add_row(bis_pkg::OP_CLEAR, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_OK, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});
    add_row(bis_pkg::OP_POP, 32'h0, 4'd0, 1, 1'b1,
            '{32'sd0, bis_pkg::ST_EMPTY, 4'd0, 5'd0, 1'b1, 32'sd0, 32'sd0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 21;
    for (k = 0; k < script.size(); k++) begin
      for (n = 0; n < script[k].reps; n++) begin
        sender_pause();
        issue(script[k].req, script[k].fixed, script[k].want);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 21 : ((phase == 1) ? 74 : 0);
      repeat (RANDOM_ITEMS / 3) begin
        sender_pause();
        issue(random_request(), 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && awaited_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The slowest correct run is well under half a millisecond.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
